[sv/mlpft_pkg.sv]
// ============================================================================
// mlpft_pkg
// Shared types, constants and the tanh knot table of the perceptron block.
// ============================================================================
`default_nettype none

package mlpft_pkg;

    // default sizing
    localparam int MAX_LAYER_SIZE  = 64;
    localparam int MAX_STAGES      = 4;
    localparam int VALUE_WIDTH     = 16;

    // fixed formats
    localparam int FRAC_BITS       = 12;
    localparam int STAGE_REG_LIMIT = 4;
    localparam int SIZE_REGS       = 5;
    localparam int ADDR_WIDTH      = 14;
    localparam int OUT_WIDTH       = 14;
    localparam int INDEX_WIDTH     = 6;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int REG_DATA_WIDTH  = 7;
    localparam int STAGE_WIDTH     = 3;
    localparam int TANH_KNOTS      = 20;
    localparam int TANH_SEG_BITS   = 10;
    localparam int KNOT_WIDTH      = 13;

    // item kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // register indexes
    localparam logic [REG_INDEX_WIDTH-1:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SIZE_LAYER0 = 3'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SIZE_LAYER4 = 3'd5;

    typedef struct packed {
        logic                          kind;
        logic [ADDR_WIDTH-1:0]         weight_address;
        logic signed [VALUE_WIDTH-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] out_value;
        logic [INDEX_WIDTH-1:0]      out_index;
        logic                        out_last;
    } out_beat_t;

    typedef struct packed {
        logic [REG_INDEX_WIDTH-1:0] reg_index;
        logic [REG_DATA_WIDTH-1:0]  wdata;
    } cfg_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ACT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } state_t;

    // neuron datapath status toward the sequencer
    typedef struct packed {
        logic pipe_empty;
        logic y_valid;
    } nrn_status_t;

    // tanh(k/4) in Q12 at the segment knots
    function automatic logic [KNOT_WIDTH-1:0] tanh_knot(input logic [4:0] k);
        logic [KNOT_WIDTH-1:0] v;
        case (k)
            5'd0:    v = 13'd0;
            5'd1:    v = 13'd1003;
            5'd2:    v = 13'd1893;
            5'd3:    v = 13'd2602;
            5'd4:    v = 13'd3119;
            5'd5:    v = 13'd3475;
            5'd6:    v = 13'd3707;
            5'd7:    v = 13'd3856;
            5'd8:    v = 13'd3949;
            5'd9:    v = 13'd4006;
            5'd10:   v = 13'd4041;
            5'd11:   v = 13'd4062;
            5'd12:   v = 13'd4076;
            5'd13:   v = 13'd4084;
            5'd14:   v = 13'd4089;
            5'd15:   v = 13'd4091;
            5'd16:   v = 13'd4093;
            5'd17:   v = 13'd4094;
            5'd18:   v = 13'd4095;
            5'd19:   v = 13'd4095;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/mlpft_stream_if.sv]
// ============================================================================
// mlpft_stream_if
// Valid/ready channel carrying one payload beat.
// ============================================================================
`default_nettype none

interface mlpft_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/mlpft_ram.sv]
// ============================================================================
// mlpft_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ============================================================================
`default_nettype none

module mlpft_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/mlpft_neuron.sv]
// ============================================================================
// mlpft_neuron
// Multiply-accumulate, rounding with saturation and piecewise tanh.
// ============================================================================
`default_nettype none

module mlpft_neuron #(
    parameter int LAYER_SIZE = mlpft_pkg::MAX_LAYER_SIZE
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     mac_valid,
    input  wire logic signed [mlpft_pkg::VALUE_WIDTH-1:0] w,
    input  wire logic signed [mlpft_pkg::VALUE_WIDTH-1:0] a,
    input  wire logic                                     finish,
    output logic signed [mlpft_pkg::OUT_WIDTH-1:0]        y,
    output mlpft_pkg::nrn_status_t                        status
);

    localparam int VW    = mlpft_pkg::VALUE_WIDTH;
    localparam int FB    = mlpft_pkg::FRAC_BITS;
    localparam int SB    = mlpft_pkg::TANH_SEG_BITS;
    localparam int KW    = mlpft_pkg::KNOT_WIDTH;
    localparam int OW    = mlpft_pkg::OUT_WIDTH;
    localparam int ACC_W = 2 * VW + $clog2(LAYER_SIZE) + 1;
    localparam int PW    = KW + SB;

    localparam logic signed [ACC_W:0] VMAX = {{(ACC_W + 2 - VW){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [ACC_W:0] VMIN = {{(ACC_W + 2 - VW){1'b1}}, {(VW - 1){1'b0}}};
    localparam logic [32:0] BIG_LIMIT = 33'(mlpft_pkg::TANH_KNOTS) << SB;
    localparam logic [KW-1:0] ONE_Q   = KW'(1 << FB);

    logic signed [2*VW-1:0] prod_reg;
    logic                   prod_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [VW-1:0]   x_reg;
    logic                   rnd_v_reg;
    logic [PW-1:0]          seg_reg;
    logic [KW-1:0]          lo_reg;
    logic                   big_reg;
    logic                   neg_reg;
    logic                   t1_v_reg;
    logic signed [OW-1:0]   y_reg;
    logic                   y_v_reg;

    logic signed [ACC_W:0]  rnd_t;
    logic signed [ACC_W:0]  rnd_q;
    logic signed [VW-1:0]   sat_x;
    logic signed [VW:0]     xe;
    logic [VW:0]            ax;
    logic [32:0]            ax33;
    logic [4:0]             k5;
    logic [KW-1:0]          knot_lo;
    logic [KW-1:0]          knot_hi;
    logic [KW-1:0]          knot_d;
    logic [PW-1:0]          seg_rnd;
    logic [KW-1:0]          mag;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= mac_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= w * a;
    end

    // accumulator, cleared when the sum is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (finish)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up to Q12 and saturate
    always_comb
    begin
        rnd_t = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(1 << (FB - 1));
        rnd_q = rnd_t >>> FB;
        if (rnd_q > VMAX)
        begin
            sat_x = VMAX[VW-1:0];
        end
        else if (rnd_q < VMIN)
        begin
            sat_x = VMIN[VW-1:0];
        end
        else
        begin
            sat_x = rnd_q[VW-1:0];
        end
    end

    // segment lookup on the magnitude
    always_comb
    begin
        xe      = {x_reg[VW-1], x_reg};
        ax      = xe[VW] ? $unsigned(-xe) : $unsigned(xe);
        ax33    = 33'(ax);
        k5      = ax33[SB+4:SB];
        knot_lo = mlpft_pkg::tanh_knot(k5);
        knot_hi = mlpft_pkg::tanh_knot(5'(k5 + 5'd1));
        knot_d  = knot_hi - knot_lo;
    end

    // interpolate; sign restored at the output
    always_comb
    begin
        seg_rnd = (seg_reg + PW'(1 << (SB - 1))) >> SB;
        mag     = big_reg ? ONE_Q : (lo_reg + seg_rnd[KW-1:0]);
    end

    // result pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_v_reg <= 1'b0;
            t1_v_reg  <= 1'b0;
            y_v_reg   <= 1'b0;
        end
        else
        begin
            rnd_v_reg <= finish;
            t1_v_reg  <= rnd_v_reg;
            y_v_reg   <= t1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= sat_x;
        seg_reg <= PW'(knot_d * ax33[SB-1:0]);
        lo_reg  <= knot_lo;
        big_reg <= ax33 >= BIG_LIMIT;
        neg_reg <= x_reg[VW-1];
        y_reg   <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign y                 = y_reg;
    assign status.y_valid    = y_v_reg;
    assign status.pipe_empty = !mac_valid && !prod_v_reg;

endmodule

`default_nettype wire

[sv/mlp_forward_tanh.sv]
// after the last element, every stage accumulates, drains and activates each output,
//   then each final output is read, loaded and held until the result side takes it
// throughput: one MAC per cycle, set by the single read port of the weight memory
// weight and element beats are taken one per cycle while the block is idle
// reset clears control registers; weight and activation memories are not cleared
// ============================================================================
// mlp_forward_tanh
// Perceptron inference in Q4.12 with tanh activations, memory based sequencer.
// ============================================================================
`default_nettype none

module mlp_forward_tanh #(
    parameter int MAX_LAYER_SIZE = mlpft_pkg::MAX_LAYER_SIZE,
    parameter int MAX_STAGES     = mlpft_pkg::MAX_STAGES
) (
    input wire logic       clk,
    input wire logic       rst_n,
    mlpft_stream_if.sink   feed,
    mlpft_stream_if.source result,
    mlpft_stream_if.sink   cfg
);

    localparam int L       = MAX_LAYER_SIZE;
    localparam int LW      = $clog2(L);
    localparam int CW      = $clog2(L + 1);
    localparam int VW      = mlpft_pkg::VALUE_WIDTH;
    localparam int OW      = mlpft_pkg::OUT_WIDTH;
    localparam int WDEPTH  = MAX_STAGES * L * L;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int AAW     = LW + 1;
    localparam int ADEPTH  = 2 << LW;
    localparam int STG_LIM = (MAX_STAGES < mlpft_pkg::STAGE_REG_LIMIT) ?
                             MAX_STAGES : mlpft_pkg::STAGE_REG_LIMIT;
    localparam int SW      = $clog2(STG_LIM + 1);
    localparam int NR      = mlpft_pkg::SIZE_REGS;

    mlpft_pkg::state_t state_reg, state_next;

    logic [mlpft_pkg::STAGE_WIDTH-1:0]    stage_count_reg;
    logic [mlpft_pkg::REG_DATA_WIDTH-1:0] size_reg [0:NR-1];
    logic [CW-1:0]         ec_reg;
    logic [SW-1:0]         s_reg;
    logic                  src_reg;
    logic [CW-1:0]         o_reg;
    logic [CW-1:0]         i_reg;
    logic [CW-1:0]         n_in_reg;
    logic [CW-1:0]         n_out_reg;
    logic [WAW-1:0]        stage_base_reg;
    logic [WAW-1:0]        row_base_reg;
    logic                  rd_v_reg;
    mlpft_pkg::out_beat_t  out_reg;
    logic                  out_v_reg;

    logic [CW-1:0]         eff_size [0:NR-1];
    logic [SW-1:0]         eff_stages;
    logic [2:0]            nxt_idx;
    logic [CW-1:0]         next_size;
    logic                  in_acc;
    logic                  cfg_acc;
    logic                  out_acc;
    logic                  is_sample;
    logic                  vec_done;
    logic                  mac_last;
    logic                  out_more;
    logic                  stage_more;
    logic                  finish;
    logic                  w_we;
    logic [WAW-1:0]        w_waddr;
    logic [WAW-1:0]        w_raddr;
    logic [VW-1:0]         w_rdata;
    logic                  a_we;
    logic [AAW-1:0]        a_waddr;
    logic [VW-1:0]         a_wdata;
    logic [AAW-1:0]        a_raddr;
    logic [VW-1:0]         a_rdata;
    logic [31:0]           wa32;
    logic [31:0]           o32;
    logic signed [OW-1:0]  nrn_y;
    mlpft_pkg::nrn_status_t nrn_st;

    // handshakes
    assign in_acc    = feed.valid && feed.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign out_acc   = result.valid && result.ready;
    assign cfg.ready = 1'b1;
    assign is_sample = feed.data.kind == mlpft_pkg::KIND_SAMPLE;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= 3'd1;
            for (int j = 0; j < NR; j++)
            begin
                size_reg[j] <= 7'd64;
            end
        end
        else if (cfg_acc)
        begin
            if (cfg.data.reg_index == mlpft_pkg::REG_STAGE_COUNT)
            begin
                stage_count_reg <= cfg.data.wdata[mlpft_pkg::STAGE_WIDTH-1:0];
            end
            else if (cfg.data.reg_index >= mlpft_pkg::REG_SIZE_LAYER0 &&
                     cfg.data.reg_index <= mlpft_pkg::REG_SIZE_LAYER4)
            begin
                size_reg[cfg.data.reg_index - mlpft_pkg::REG_SIZE_LAYER0] <= cfg.data.wdata;
            end
        end
    end

    // clamp sizes and stage count
    always_comb
    begin
        for (int j = 0; j < NR; j++)
        begin
            if (size_reg[j] == '0)
            begin
                eff_size[j] = CW'(1);
            end
            else if (32'(size_reg[j]) > L)
            begin
                eff_size[j] = CW'(L);
            end
            else
            begin
                eff_size[j] = CW'(size_reg[j]);
            end
        end
        if (stage_count_reg == '0)
        begin
            eff_stages = SW'(1);
        end
        else if (32'(stage_count_reg) > STG_LIM)
        begin
            eff_stages = SW'(STG_LIM);
        end
        else
        begin
            eff_stages = SW'(stage_count_reg);
        end
        nxt_idx   = 3'(s_reg) + 3'd2;
        next_size = (nxt_idx < 3'(NR)) ? eff_size[nxt_idx] : CW'(1);
    end

    // loop conditions
    assign vec_done   = in_acc && is_sample &&
                        ({1'b0, ec_reg} + (CW + 1)'(1) >= {1'b0, eff_size[0]});
    assign mac_last   = {1'b0, i_reg} + (CW + 1)'(1) >= {1'b0, n_in_reg};
    assign out_more   = {1'b0, o_reg} + (CW + 1)'(1) < {1'b0, n_out_reg};
    assign stage_more = {1'b0, s_reg} + (SW + 1)'(1) < {1'b0, eff_stages};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlpft_pkg::S_IDLE:
            begin
                if (vec_done)
                begin
                    state_next = mlpft_pkg::S_MAC;
                end
            end
            mlpft_pkg::S_MAC:
            begin
                if (mac_last)
                begin
                    state_next = mlpft_pkg::S_DRAIN;
                end
            end
            mlpft_pkg::S_DRAIN:
            begin
                if (nrn_st.pipe_empty)
                begin
                    state_next = mlpft_pkg::S_ACT;
                end
            end
            mlpft_pkg::S_ACT:
            begin
                if (nrn_st.y_valid)
                begin
                    state_next = (out_more || stage_more) ? mlpft_pkg::S_MAC
                                                          : mlpft_pkg::S_EMIT_RD;
                end
            end
            mlpft_pkg::S_EMIT_RD:
            begin
                state_next = mlpft_pkg::S_EMIT_LD;
            end
            mlpft_pkg::S_EMIT_LD:
            begin
                state_next = mlpft_pkg::S_EMIT_HOLD;
            end
            mlpft_pkg::S_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    state_next = out_reg.out_last ? mlpft_pkg::S_IDLE
                                                  : mlpft_pkg::S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = mlpft_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        wa32       = 32'(feed.data.weight_address);
        feed.ready = state_reg == mlpft_pkg::S_IDLE;
        finish     = (state_reg == mlpft_pkg::S_DRAIN) && nrn_st.pipe_empty;
        w_we       = (state_reg == mlpft_pkg::S_IDLE) && in_acc && !is_sample &&
                     (wa32 < WDEPTH);
        w_waddr    = wa32[WAW-1:0];
        w_raddr    = row_base_reg + WAW'(i_reg);
        a_we       = 1'b0;
        a_waddr    = {1'b0, ec_reg[LW-1:0]};
        a_wdata    = feed.data.value;
        a_raddr    = {src_reg, i_reg[LW-1:0]};
        case (state_reg)
            mlpft_pkg::S_IDLE:
            begin
                a_we = in_acc && is_sample && (32'(ec_reg) < L);
            end
            mlpft_pkg::S_ACT:
            begin
                a_we    = nrn_st.y_valid;
                a_waddr = {~src_reg, o_reg[LW-1:0]};
                a_wdata = VW'(nrn_y);
            end
            mlpft_pkg::S_EMIT_RD:
            begin
                a_raddr = {src_reg, o_reg[LW-1:0]};
            end
            default:
            begin
                a_we = 1'b0;
            end
        endcase
    end

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mlpft_pkg::S_IDLE;
            ec_reg         <= '0;
            s_reg          <= '0;
            src_reg        <= 1'b0;
            o_reg          <= '0;
            i_reg          <= '0;
            n_in_reg       <= CW'(1);
            n_out_reg      <= CW'(1);
            stage_base_reg <= '0;
            row_base_reg   <= '0;
            rd_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= state_reg == mlpft_pkg::S_MAC;
            case (state_reg)
                mlpft_pkg::S_IDLE:
                begin
                    if (in_acc && is_sample)
                    begin
                        ec_reg <= vec_done ? '0 : ec_reg + CW'(1);
                    end
                    if (vec_done)
                    begin
                        s_reg          <= '0;
                        src_reg        <= 1'b0;
                        o_reg          <= '0;
                        i_reg          <= '0;
                        n_in_reg       <= eff_size[0];
                        n_out_reg      <= eff_size[1];
                        stage_base_reg <= '0;
                        row_base_reg   <= '0;
                    end
                end
                mlpft_pkg::S_MAC:
                begin
                    if (!mac_last)
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                mlpft_pkg::S_ACT:
                begin
                    if (nrn_st.y_valid)
                    begin
                        i_reg <= '0;
                        if (out_more)
                        begin
                            o_reg        <= o_reg + CW'(1);
                            row_base_reg <= row_base_reg + WAW'(L);
                        end
                        else if (stage_more)
                        begin
                            s_reg          <= s_reg + SW'(1);
                            src_reg        <= ~src_reg;
                            o_reg          <= '0;
                            n_in_reg       <= n_out_reg;
                            n_out_reg      <= next_size;
                            stage_base_reg <= stage_base_reg + WAW'(L * L);
                            row_base_reg   <= stage_base_reg + WAW'(L * L);
                        end
                        else
                        begin
                            src_reg <= ~src_reg;
                            o_reg   <= '0;
                        end
                    end
                end
                mlpft_pkg::S_EMIT_LD:
                begin
                    out_v_reg <= 1'b1;
                end
                mlpft_pkg::S_EMIT_HOLD:
                begin
                    if (out_acc)
                    begin
                        out_v_reg <= 1'b0;
                        o_reg     <= o_reg + CW'(1);
                    end
                end
                default:
                begin
                    out_v_reg <= out_v_reg;
                end
            endcase
        end
    end

    // result beat register
    assign o32 = 32'(o_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == mlpft_pkg::S_EMIT_LD)
        begin
            out_reg.out_value <= a_rdata[OW-1:0];
            out_reg.out_index <= o32[mlpft_pkg::INDEX_WIDTH-1:0];
            out_reg.out_last  <= {1'b0, o_reg} + (CW + 1)'(1) == {1'b0, n_out_reg};
        end
    end

    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    // weight memory
    mlpft_ram #(
        .DEPTH (WDEPTH),
        .WIDTH (VW)
    ) u_wmem (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (feed.data.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // activation ping-pong rows
    mlpft_ram #(
        .DEPTH (ADEPTH),
        .WIDTH (VW)
    ) u_amem (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // neuron datapath
    mlpft_neuron #(
        .LAYER_SIZE (L)
    ) u_neuron (
        .clk       (clk),
        .rst_n     (rst_n),
        .mac_valid (rd_v_reg),
        .w         ($signed(w_rdata)),
        .a         ($signed(a_rdata)),
        .finish    (finish),
        .y         (nrn_y),
        .status    (nrn_st)
    );

    // checks
    a_no_feed_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !feed.ready)
        else $error("input taken while a result is pending");

    a_no_act_write_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mlpft_pkg::S_MAC |-> !a_we)
        else $error("activation write during accumulation");

    a_y_only_in_act: assert property (@(posedge clk) disable iff (!rst_n)
        nrn_st.y_valid |-> state_reg == mlpft_pkg::S_ACT)
        else $error("neuron result outside activation step");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && result.data.out_last) |=> state_reg == mlpft_pkg::S_IDLE)
        else $error("sequencer not idle after last beat");

endmodule

`default_nettype wire

[tb/mlp_forward_tanh_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// mlp_forward_tanh_tb
// Self-checking bench: weight and sample beats are driven in, each vector's
// final-layer outputs are predicted in fixed point and compared as they leave.
// ============================================================================
`default_nettype none

module mlp_forward_tanh_tb;

    localparam int MAX_LAYER_SIZE = mlpft_pkg::MAX_LAYER_SIZE;
    localparam int MAX_STAGES     = mlpft_pkg::MAX_STAGES;
    localparam int SIZE_REGS      = mlpft_pkg::SIZE_REGS;
    localparam int STORE_DEPTH    = MAX_STAGES * MAX_LAYER_SIZE * MAX_LAYER_SIZE;
    localparam int CYCLE_LIMIT    = 3000000;
    localparam int HOLD_CYCLES    = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mlpft_stream_if #(.payload_t(mlpft_pkg::in_beat_t))  feed_if ();
    mlpft_stream_if #(.payload_t(mlpft_pkg::out_beat_t)) result_if ();
    mlpft_stream_if #(.payload_t(mlpft_pkg::cfg_beat_t)) cfg_if ();

    mlp_forward_tanh DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if.sink),
        .result (result_if.source),
        .cfg    (cfg_if.sink)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] weights [STORE_DEPTH];
    bit                 weight_known [STORE_DEPTH];
    logic signed [15:0] acts [2][MAX_LAYER_SIZE];
    int unsigned        elem_count;
    logic [2:0]         stage_reg;
    logic [6:0]         size_reg [SIZE_REGS];

    mlpft_pkg::in_beat_t  feed_queue [$];
    mlpft_pkg::out_beat_t expected_outputs [$];
    int        error_count;
    int        cycle_count;
    bit        hold_off = 1'b0;
    bit        hold_req = 1'b0;
    bit        feed_fire = 1'b0;

    int tanh_table [21] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006,
                            4041, 4062, 4076, 4084, 4089, 4091, 4093, 4094, 4095,
                            4095, 4096};

    function automatic int clamp_size(input int s);
        if (s < 1) return 1;
        if (s > MAX_LAYER_SIZE) return MAX_LAYER_SIZE;
        return s;
    endfunction

    function automatic int tanh_q12(input longint x);
        longint a, k, f, m;
        a = (x < 0) ? -x : x;
        k = a / 1024;
        f = a % 1024;
        if (k >= 20)
            m = 4096;
        else
            m = tanh_table[k] + ((tanh_table[k+1] - tanh_table[k]) * f + 512) / 1024;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint round_q12(input longint acc);
        longint t, q;
        t = acc + 2048;
        q = (t >= 0) ? t / 4096 : -((-t + 4095) / 4096);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // append helpers for the beat queues
    task automatic enqueue(input mlpft_pkg::in_beat_t b);
        feed_queue = {feed_queue, b};
    endtask

    task automatic expect_beat(input mlpft_pkg::out_beat_t r);
        expected_outputs = {expected_outputs, r};
    endtask

    // store weights; a full vector is run forward, queueing the final outputs
    task automatic predict_beat(input mlpft_pkg::in_beat_t b);
        int stages, src, dst, n_in, n_out;
        longint acc;
        mlpft_pkg::out_beat_t r;
        if (b.kind == mlpft_pkg::KIND_WEIGHT)
        begin
            if (b.weight_address < STORE_DEPTH)
            begin
                weights[b.weight_address] = b.value;
                weight_known[b.weight_address] = 1'b1;
            end
            return;
        end
        if (elem_count < MAX_LAYER_SIZE)
            acts[0][elem_count] = b.value;
        elem_count++;
        if (elem_count < clamp_size(size_reg[0]))
            return;
        elem_count = 0;
        stages = (stage_reg < 1) ? 1 : (stage_reg > MAX_STAGES) ? MAX_STAGES : stage_reg;
        src = 0;
        n_in = clamp_size(size_reg[0]);
        n_out = n_in;
        for (int s = 0; s < stages; s++)
        begin
            dst = 1 - src;
            n_out = clamp_size(size_reg[s+1]);
            for (int o = 0; o < n_out; o++)
            begin
                acc = 0;
                for (int i = 0; i < n_in; i++)
                    acc += longint'(weights[s*4096 + o*64 + i]) * longint'(acts[src][i]);
                acts[dst][o] = 16'(tanh_q12(round_q12(acc)));
            end
            src = dst;
            n_in = n_out;
        end
        for (int o = 0; o < n_out; o++)
        begin
            r.out_value = acts[src][o][13:0];
            r.out_index = 6'(o);
            r.out_last  = (o + 1 == n_out);
            expect_beat(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // input beat taken at this edge
    always @(posedge clk)
    begin
        feed_fire = rst_n && feed_if.valid && feed_if.ready;
    end

    // driver: feed beats from the queue with random gaps
    int feed_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (feed_fire)
            begin
                predict_beat(feed_if.data);
                void'(feed_queue.pop_front());
                feed_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                         : ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
            end
            // a waiting beat stays as it is
            if (!feed_if.valid || feed_fire)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    feed_if.valid <= 1'b0;
                end
                else if (feed_queue.size() > 0)
                begin
                    feed_if.valid <= 1'b1;
                    feed_if.data  <= feed_queue[0];
                end
                else
                    feed_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // sink ready with random stalls, long hold-off when requested
    int sink_gap = 0;
    always @(negedge clk)
    begin
        if (hold_off)
            result_if.ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap--;
            result_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            sink_gap = $urandom_range(5, 40);
            result_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
            result_if.ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            result_if.ready <= $urandom_range(0, 1);
        else
            result_if.ready <= 1'b1;
    end

    // monitor: compare accepted results against the oldest expectation
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                if (result_if.data.out_value !== expected_outputs[0].out_value)
                    report_mismatch($sformatf("out_value got %0d exp %0d",
                        result_if.data.out_value, expected_outputs[0].out_value));
                if (result_if.data.out_index !== expected_outputs[0].out_index)
                    report_mismatch($sformatf("out_index got %0d exp %0d",
                        result_if.data.out_index, expected_outputs[0].out_index));
                if (result_if.data.out_last !== expected_outputs[0].out_last)
                    report_mismatch($sformatf("out_last got %0b exp %0b",
                        result_if.data.out_last, expected_outputs[0].out_last));
                void'(expected_outputs.pop_front());
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    // register write through the config channel, mirrored into the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: idx, wdata: data};
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == mlpft_pkg::REG_STAGE_COUNT)
            stage_reg = data[2:0];
        else if (idx <= mlpft_pkg::REG_SIZE_LAYER4)
            size_reg[idx-1] = data;
    endtask

    // wait until every queued beat is taken and every result has come back
    task automatic drain();
        while (feed_queue.size() > 0 || feed_if.valid || expected_outputs.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // weights for every input of every used output, then the vectors
    task automatic load_network(input int n_vectors);
        int stages, n_in, n_out;
        mlpft_pkg::in_beat_t b;
        stages = (stage_reg < 1) ? 1 : (stage_reg > MAX_STAGES) ? MAX_STAGES : stage_reg;
        n_in = clamp_size(size_reg[0]);
        for (int s = 0; s < stages; s++)
        begin
            n_out = clamp_size(size_reg[s+1]);
            for (int o = 0; o < n_out; o++)
                for (int i = 0; i < n_in; i++)
                begin
                    b.kind = mlpft_pkg::KIND_WEIGHT;
                    b.weight_address = 14'(s*4096 + o*64 + i);
                    b.value = ($urandom_range(0, 3) == 0) ? rand_value()
                            : 16'($urandom_range(0, 4095) - 2048);
                    enqueue(b);
                end
            n_in = n_out;
        end
        for (int v = 0; v < n_vectors * clamp_size(size_reg[0]); v++)
        begin
            b.kind = mlpft_pkg::KIND_SAMPLE;
            b.weight_address = 14'($urandom());
            b.value = rand_value();
            enqueue(b);
        end
    endtask

    function automatic bit network_loaded();
        int stages, n_in, n_out;
        stages = (stage_reg < 1) ? 1 : (stage_reg > MAX_STAGES) ? MAX_STAGES : stage_reg;
        n_in = clamp_size(size_reg[0]);
        for (int s = 0; s < stages; s++)
        begin
            n_out = clamp_size(size_reg[s+1]);
            for (int o = 0; o < n_out; o++)
                for (int i = 0; i < n_in; i++)
                    if (!weight_known[s*4096 + o*64 + i]) return 1'b0;
            n_in = n_out;
        end
        return 1'b1;
    endfunction

    task automatic set_config(input logic [2:0] st, input logic [6:0] s0,
                              input logic [6:0] s1, input logic [6:0] s2,
                              input logic [6:0] s3, input logic [6:0] s4);
        write_reg(mlpft_pkg::REG_STAGE_COUNT, st);
        write_reg(mlpft_pkg::REG_SIZE_LAYER0, s0);
        write_reg(mlpft_pkg::REG_SIZE_LAYER0 + 3'd1, s1);
        write_reg(mlpft_pkg::REG_SIZE_LAYER0 + 3'd2, s2);
        write_reg(mlpft_pkg::REG_SIZE_LAYER0 + 3'd3, s3);
        write_reg(mlpft_pkg::REG_SIZE_LAYER4, s4);
    endtask

    // stimulus
    initial
    begin
        mlpft_pkg::in_beat_t b;
        feed_if.valid = 1'b0;
        feed_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        result_if.ready = 1'b0;
        elem_count = 0;
        stage_reg = 3'd1;
        for (int i = 0; i < SIZE_REGS; i++) size_reg[i] = 7'd64;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: small net, extreme values, top address, zero and oversize regs
        set_config(3'd1, 7'd2, 7'd3, 7'd1, 7'd1, 7'd1);
        load_network(0);
        b = '{kind: mlpft_pkg::KIND_WEIGHT, weight_address: 14'h3FFF, value: 16'sh7FFF};
        enqueue(b);
        foreach (feed_queue[i])
            if (i < 6 && feed_queue[i].kind == mlpft_pkg::KIND_WEIGHT)
                feed_queue[i].value = (i % 2) ? 16'sh8000 : 16'sh7FFF;
        for (int v = 0; v < 4; v++)
        begin
            b = '{kind: mlpft_pkg::KIND_SAMPLE, weight_address: 14'h3FFF,
                  value: (v % 2) ? 16'sh8000 : 16'sh7FFF};
            enqueue(b);
        end
        drain();
        set_config(3'd0, 7'd0, 7'd127, 7'd0, 7'd0, 7'd0);
        load_network(1);
        drain();
        set_config(3'd7, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
        load_network(2);
        drain();

        // size lowered mid-vector: leftover count finishes the next vector at once
        set_config(3'd1, 7'd3, 7'd2, 7'd1, 7'd1, 7'd1);
        load_network(0);
        for (int v = 0; v < 2; v++)
        begin
            b = '{kind: mlpft_pkg::KIND_SAMPLE, weight_address: 14'd0, value: rand_value()};
            enqueue(b);
        end
        drain();
        write_reg(mlpft_pkg::REG_SIZE_LAYER0, 7'd1);
        b = '{kind: mlpft_pkg::KIND_SAMPLE, weight_address: 14'd0, value: 16'sh1000};
        enqueue(b);
        drain();

        // widest output layer, one stage, with the sink held off
        set_config(3'd1, 7'd2, 7'd64, 7'd1, 7'd1, 7'd1);
        load_network(2);
        while (feed_queue.size() > 2) @(posedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        drain();

        // random phases with small sizes
        for (int p = 0; p < 3; p++)
        begin
            set_config($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 8),
                       $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8));
            if (!network_loaded() || $urandom_range(0, 1))
                load_network(0);
            for (int v = 0; v < 4; v++)
            begin
                for (int e = 0; e < clamp_size(size_reg[0]); e++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        b.kind = mlpft_pkg::KIND_WEIGHT;
                        b.weight_address = 14'($urandom_range(0, 63));
                        b.value = rand_value();
                        enqueue(b);
                    end
                    b.kind = mlpft_pkg::KIND_SAMPLE;
                    b.weight_address = 14'($urandom());
                    b.value = rand_value();
                    enqueue(b);
                end
            end
            drain();
        end

        drain();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[mlp_forward_tanh.f]
sv/mlpft_pkg.sv
sv/mlpft_stream_if.sv
sv/mlpft_ram.sv
sv/mlpft_neuron.sv
sv/mlp_forward_tanh.sv
tb/mlp_forward_tanh_tb.sv
